// File: design/i2c_master_transaction_sequencer_top_defines.svh
// Assertion macros for the I2C master transaction sequencer.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CMTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c sequencer check failed");

// Next-cycle implication, disabled during reset.
`define I2CMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c sequencer check failed");

`endif

// File: design/i2cmts_pkg.sv
`timescale 1ns / 1ps

package i2cmts_pkg;

    // Command opcodes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DONE  = 1'b1;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_W_START = 3'd1;
    localparam logic [2:0] PH_W_ADDR  = 3'd2;
    localparam logic [2:0] PH_W_DATA  = 3'd3;
    localparam logic [2:0] PH_R_START = 3'd4;
    localparam logic [2:0] PH_R_ADDR  = 3'd5;
    localparam logic [2:0] PH_R_DATA  = 3'd6;

    // Bus actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_TX    = 3'd2;
    localparam logic [2:0] ACT_RACK  = 3'd3;
    localparam logic [2:0] ACT_RNACK = 3'd4;
    localparam logic [2:0] ACT_STOP  = 3'd5;

    // Transaction outcomes
    localparam logic [1:0] OC_OK         = 2'd0;
    localparam logic [1:0] OC_NAK        = 2'd1;
    localparam logic [1:0] OC_UNEXPECTED = 2'd2;

    // Bus status codes (after masking)
    localparam logic [7:0] ST_MASK       = 8'hf8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
    localparam logic [7:0] ST_SLA_W_NAK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_DATA_W_NAK = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
    localparam logic [7:0] ST_SLA_R_NAK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
    localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

    // Address byte R/W handling
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hfe;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

    typedef struct packed {
        logic        op;
        logic [7:0]  device_address;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_value;
        logic       rx_valid;
        logic [7:0] rx_value;
        logic       done_res;
        logic [1:0] outcome;
        logic [7:0] final_status;
    } res_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  address_byte;
        logic [15:0] writes_left;
        logic [15:0] reads_left;
        logic        wrote_flag;
    } seq_state_t;

endpackage

// File: design/i2cmts_step.sv
`timescale 1ns / 1ps

module i2cmts_step
(
    input  i2cmts_pkg::seq_state_t cur,
    input  i2cmts_pkg::cmd_t       cmd,
    output i2cmts_pkg::seq_state_t nxt,
    output i2cmts_pkg::res_t       res
);

    logic [7:0]  st_masked;
    logic [7:0]  w_ok_code;
    logic [7:0]  w_nak_code;
    logic [7:0]  rs_code;
    logic [7:0]  rd_code;
    logic [15:0] rl_dec;
    logic        unexpected;

    // Status codes expected in the current phase
    assign st_masked  = cmd.bus_status & i2cmts_pkg::ST_MASK;
    assign w_ok_code  = (cur.phase == i2cmts_pkg::PH_W_ADDR) ? i2cmts_pkg::ST_SLA_W_ACK
                                                             : i2cmts_pkg::ST_DATA_W_ACK;
    assign w_nak_code = (cur.phase == i2cmts_pkg::PH_W_ADDR) ? i2cmts_pkg::ST_SLA_W_NAK
                                                             : i2cmts_pkg::ST_DATA_W_NAK;
    assign rs_code    = cur.wrote_flag ? i2cmts_pkg::ST_RSTART : i2cmts_pkg::ST_START;
    assign rd_code    = (cur.reads_left > 16'd1) ? i2cmts_pkg::ST_DATA_R_ACK
                                                 : i2cmts_pkg::ST_DATA_R_NAK;
    assign rl_dec     = (cur.reads_left != 16'd0) ? cur.reads_left - 16'd1 : 16'd0;

    // Next state and result for one transaction
    always_comb
    begin
        nxt        = cur;
        res        = '0;
        res.action = i2cmts_pkg::ACT_NONE;
        unexpected = 1'b0;

        if (cmd.op == i2cmts_pkg::OP_BEGIN)
        begin
            nxt.address_byte = cmd.device_address;
            nxt.writes_left  = cmd.write_count;
            nxt.reads_left   = cmd.read_count;
            if (cmd.write_count != 16'd0)
            begin
                nxt.wrote_flag = 1'b1;
                nxt.phase      = i2cmts_pkg::PH_W_START;
                res.action     = i2cmts_pkg::ACT_START;
            end
            else if (cmd.read_count != 16'd0)
            begin
                nxt.wrote_flag = 1'b0;
                nxt.phase      = i2cmts_pkg::PH_R_START;
                res.action     = i2cmts_pkg::ACT_START;
            end
            else
            begin
                // empty transaction finishes at once
                nxt.wrote_flag = 1'b0;
                nxt.phase      = i2cmts_pkg::PH_IDLE;
                res.done_res   = 1'b1;
            end
        end
        else
        begin
            unique case (cur.phase) inside
                i2cmts_pkg::PH_W_START:
                begin
                    if (st_masked == i2cmts_pkg::ST_START)
                    begin
                        nxt.phase    = i2cmts_pkg::PH_W_ADDR;
                        res.action   = i2cmts_pkg::ACT_TX;
                        res.tx_value = cur.address_byte & i2cmts_pkg::ADDR_WRITE_MASK;
                    end
                    else
                    begin
                        unexpected = 1'b1;
                    end
                end
                i2cmts_pkg::PH_W_ADDR, i2cmts_pkg::PH_W_DATA:
                begin
                    if (st_masked == w_ok_code)
                    begin
                        if (cur.writes_left != 16'd0)
                        begin
                            nxt.writes_left = cur.writes_left - 16'd1;
                            nxt.phase       = i2cmts_pkg::PH_W_DATA;
                            res.action      = i2cmts_pkg::ACT_TX;
                            res.tx_value    = cmd.tx_byte;
                        end
                        else if (cur.reads_left != 16'd0)
                        begin
                            nxt.phase  = i2cmts_pkg::PH_R_START;
                            res.action = i2cmts_pkg::ACT_START;
                        end
                        else
                        begin
                            nxt.phase    = i2cmts_pkg::PH_IDLE;
                            res.action   = i2cmts_pkg::ACT_STOP;
                            res.done_res = 1'b1;
                        end
                    end
                    else if (st_masked == w_nak_code)
                    begin
                        nxt.phase        = i2cmts_pkg::PH_IDLE;
                        res.action       = i2cmts_pkg::ACT_STOP;
                        res.done_res     = 1'b1;
                        res.outcome      = i2cmts_pkg::OC_NAK;
                        res.final_status = st_masked;
                    end
                    else
                    begin
                        unexpected = 1'b1;
                    end
                end
                i2cmts_pkg::PH_R_START:
                begin
                    if (st_masked == rs_code)
                    begin
                        nxt.phase    = i2cmts_pkg::PH_R_ADDR;
                        res.action   = i2cmts_pkg::ACT_TX;
                        res.tx_value = cur.address_byte | i2cmts_pkg::ADDR_READ_BIT;
                    end
                    else
                    begin
                        unexpected = 1'b1;
                    end
                end
                i2cmts_pkg::PH_R_ADDR:
                begin
                    if (st_masked == i2cmts_pkg::ST_SLA_R_ACK)
                    begin
                        nxt.phase  = i2cmts_pkg::PH_R_DATA;
                        res.action = (cur.reads_left > 16'd1) ? i2cmts_pkg::ACT_RACK
                                                              : i2cmts_pkg::ACT_RNACK;
                    end
                    else if (st_masked == i2cmts_pkg::ST_SLA_R_NAK)
                    begin
                        nxt.phase        = i2cmts_pkg::PH_IDLE;
                        res.action       = i2cmts_pkg::ACT_STOP;
                        res.done_res     = 1'b1;
                        res.outcome      = i2cmts_pkg::OC_NAK;
                        res.final_status = st_masked;
                    end
                    else
                    begin
                        unexpected = 1'b1;
                    end
                end
                i2cmts_pkg::PH_R_DATA:
                begin
                    if (st_masked == rd_code)
                    begin
                        nxt.reads_left = rl_dec;
                        res.rx_valid   = 1'b1;
                        res.rx_value   = cmd.rx_byte;
                        if (rl_dec != 16'd0)
                        begin
                            nxt.phase  = i2cmts_pkg::PH_R_DATA;
                            res.action = (rl_dec > 16'd1) ? i2cmts_pkg::ACT_RACK
                                                          : i2cmts_pkg::ACT_RNACK;
                        end
                        else
                        begin
                            nxt.phase    = i2cmts_pkg::PH_IDLE;
                            res.action   = i2cmts_pkg::ACT_STOP;
                            res.done_res = 1'b1;
                        end
                    end
                    else
                    begin
                        unexpected = 1'b1;
                    end
                end
                default:
                begin
                    // bus event while idle is ignored
                    nxt.phase = i2cmts_pkg::PH_IDLE;
                end
            endcase
        end

        // unexpected status: finish without STOP
        if (unexpected)
        begin
            nxt.phase        = i2cmts_pkg::PH_IDLE;
            res.action       = i2cmts_pkg::ACT_NONE;
            res.done_res     = 1'b1;
            res.outcome      = i2cmts_pkg::OC_UNEXPECTED;
            res.final_status = st_masked;
        end
    end

endmodule

// File: design/i2c_master_transaction_sequencer_top.sv
`timescale 1ns / 1ps
// I2C master transaction sequencer.
// Command channel (cmd_valid/cmd_ready/cmd): op 0 begins a transaction with
// device address, write count and read count; op 1 reports that the previous
// bus action finished, with the raw bus status, the received byte and the
// next byte to send. Every command yields exactly one result on the result
// channel (res_valid/res_ready/res): the next bus action, any byte read, and
// the done flag with outcome and failing status.
// Order: a command is held in the input register, and its result is then
// registered into the result register once the sequencer advances on it.
// Throughput: one command per cycle while results are taken; the sequencer
// state updates in the same step that loads the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more command; cmd_ready falls once both are full.
// Reset clears both valid flags and returns the sequencer to idle with the
// address and counters at zero.

module i2c_master_transaction_sequencer_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  i2cmts_pkg::cmd_t  cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output i2cmts_pkg::res_t  res
);

    i2cmts_pkg::cmd_t       cmd_reg;
    logic                   cmd_valid_reg;
    i2cmts_pkg::res_t       res_reg;
    logic                   res_valid_reg;
    i2cmts_pkg::seq_state_t state_reg;
    i2cmts_pkg::seq_state_t state_next;
    i2cmts_pkg::res_t       res_next;
    logic                   advance;
    logic                   take;

    // Handshake: process when the result register is free or draining
    assign advance   = cmd_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !cmd_valid_reg || advance;
    assign take      = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    i2cmts_step u_step
    (
        .cur (state_reg),
        .cmd (cmd_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // Control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                cmd_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: design/i2cmts_checker.sv
`timescale 1ns / 1ps
`include "i2c_master_transaction_sequencer_top_defines.svh"

module i2cmts_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input i2cmts_pkg::cmd_t cmd,
    input logic             res_valid,
    input logic             res_ready,
    input i2cmts_pkg::res_t res
);

    logic cmd_stall;
    logic res_stall;
    logic open_clean;
    logic tx_clean;
    logic nak_res;
    logic nak_stop;

    // Stall conditions and per-result field checks
    assign cmd_stall  = cmd_valid && !cmd_ready;
    assign res_stall  = res_valid && !res_ready;
    assign open_clean = (res.outcome == i2cmts_pkg::OC_OK) && (res.final_status == 8'd0);
    assign tx_clean   = (res.action == i2cmts_pkg::ACT_TX) || (res.tx_value == 8'd0);
    assign nak_res    = (res.outcome == i2cmts_pkg::OC_NAK);
    assign nak_stop   = (res.action == i2cmts_pkg::ACT_STOP) && res.done_res;

    // A stalled transaction holds on the command side
    `I2CMTS_ASSERT_NEXT(a_cmd_hold, clk, rst_n, cmd_stall, cmd_valid && $stable(cmd))

    // A stalled result holds
    `I2CMTS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid && $stable(res))

    // Unfinished results carry no outcome or status
    `I2CMTS_ASSERT_NOW(a_open_clean, clk, rst_n, res_valid && !res.done_res, open_clean)

    // tx_value only accompanies a transmit action
    `I2CMTS_ASSERT_NOW(a_tx_only, clk, rst_n, res_valid, tx_clean)

    // A NAK always sends STOP and finishes
    `I2CMTS_ASSERT_NOW(a_nak_stop, clk, rst_n, res_valid && nak_res, nak_stop)

endmodule

bind i2c_master_transaction_sequencer_top i2cmts_checker u_checker (.*);
